[rtl/core/assert_macros.svh]
// assertion macros shared by the merge heap rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: label");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lmh_pkg.sv]
// types, codes and the record order of the merge heap
// used by lmh_heap, lmh_filter and the top level
package lmh_pkg;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_INS_POP = 2'd1;
	localparam logic [1:0] CMD_POP     = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	localparam logic [7:0] OP_TOMBSTONE = 8'd1;

	localparam logic REG_SNAPSHOT = 1'b0;
	localparam logic REG_BOTTOM   = 1'b1;

	typedef struct packed {
		logic [3:0]  stream;
		logic [3:0]  len;
		logic [7:0]  op;
		logic [63:0] key;
		logic [63:0] seq;
		logic [31:0] tag;
	} rec_t;

	typedef struct packed {
		logic empty;
		rec_t rec;
	} pop_t;

	typedef struct packed {
		logic idle;
		logic full;
	} heap_stat_t;

	// key, then length ascending, sequence descending, stream ascending
	function automatic logic sorts_before(rec_t a, rec_t b);
		logic res;
		if (a.key != b.key) res = a.key < b.key;
		else if (a.len != b.len) res = a.len < b.len;
		else if (a.seq != b.seq) res = a.seq > b.seq;
		else res = a.stream < b.stream;
		return res;
	endfunction

	// saturate length and clear padding bytes
	function automatic rec_t clean_rec(rec_t raw, logic [3:0] kb);
		rec_t r;
		logic [3:0] l;
		logic [6:0] sh;
		r = raw;
		l = (raw.len > kb) ? kb : raw.len;
		sh = 7'd64 - {l, 3'b000};
		r.len = l;
		r.key = (l == 4'd0) ? 64'd0 : (raw.key & ({64{1'b1}} << sh));
		return r;
	endfunction

endpackage

[rtl/core/lmh_heap.sv]
// heap memory and sift sequencer of the merge heap
// depends on lmh_pkg
module lmh_heap #(
	parameter int STREAMS = 16,
	parameter int KEY_BYTES = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               in_cmd,
	input  lmh_pkg::rec_t            in_rec,
	output logic                     pop_valid,
	input  logic                     pop_ready,
	output lmh_pkg::pop_t            pop,
	output lmh_pkg::heap_stat_t      stat,
	output logic [$clog2(STREAMS+1)-1:0] count
);
	import lmh_pkg::*;

	localparam int IW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int CW = $clog2(STREAMS + 1);
	localparam int XW = CW + 1;
	localparam logic [3:0] KB = 4'(KEY_BYTES);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_UP_RD    = 3'd1;
	localparam logic [2:0] ST_UP_CMP   = 3'd2;
	localparam logic [2:0] ST_POP_RD   = 3'd3;
	localparam logic [2:0] ST_POP_TAKE = 3'd4;
	localparam logic [2:0] ST_DN_RD    = 3'd5;
	localparam logic [2:0] ST_DN_CMP   = 3'd6;
	localparam logic [2:0] ST_RESULT   = 3'd7;

	logic [2:0]    state_q, state_d;
	logic          pop_q, pop_d;
	rec_t          rec_q, rec_d;
	pop_t          top_q, top_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;

	rec_t          mem [STREAMS];
	rec_t          rd_a_q, rd_b_q;
	logic [IW-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic          wr_en;
	rec_t          wr_data;

	logic [IW-1:0] parent;
	logic [XW-1:0] lx, rx;
	logic          l_ok, r_ok, l_best, r_over_l, r_over_rec, r_wins;
	logic [IW-1:0] l_addr, r_addr;
	logic [CW-1:0] last;

	// child and parent positions
	always_comb begin
		parent = (idx_q - IW'(1)) >> 1;
		lx = (XW'(idx_q) << 1) + XW'(1);
		rx = lx + XW'(1);
		l_ok = lx < XW'(count_q);
		r_ok = rx < XW'(count_q);
		l_addr = l_ok ? lx[IW-1:0] : '0;
		r_addr = r_ok ? rx[IW-1:0] : '0;
		last = count_q - CW'(1);
		l_best = l_ok && sorts_before(rd_a_q, rec_q);
		r_over_rec = r_ok && sorts_before(rd_b_q, rec_q);
		r_over_l = r_ok && sorts_before(rd_b_q, rd_a_q);
		r_wins = l_best ? r_over_l : r_over_rec;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		pop_d = pop_q;
		rec_d = rec_q;
		top_d = top_q;
		idx_d = idx_q;
		count_d = count_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = rec_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					rec_d = clean_rec(in_rec, KB);
					pop_d = (in_cmd == CMD_INS_POP);
					unique case (in_cmd) inside
						CMD_LOAD, CMD_INS_POP: begin
							if (count_q < CW'(STREAMS)) begin
								idx_d = count_q[IW-1:0];
								count_d = count_q + CW'(1);
								state_d = ST_UP_RD;
							end else if (in_cmd == CMD_INS_POP) begin
								state_d = ST_POP_RD;
							end
						end
						CMD_POP: state_d = ST_POP_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_UP_RD: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
					state_d = pop_q ? ST_POP_RD : ST_IDLE;
				end else begin
					rd_addr_a = parent;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (sorts_before(rec_q, rd_a_q)) begin
					wr_data = rd_a_q;
					idx_d = parent;
					state_d = ST_UP_RD;
				end else begin
					state_d = pop_q ? ST_POP_RD : ST_IDLE;
				end
			end
			ST_POP_RD: begin
				if (count_q == '0) begin
					top_d.empty = 1'b1;
					top_d.rec = '0;
					state_d = ST_RESULT;
				end else begin
					rd_addr_a = '0;
					rd_addr_b = last[IW-1:0];
					count_d = last;
					state_d = ST_POP_TAKE;
				end
			end
			ST_POP_TAKE: begin
				top_d.empty = 1'b0;
				top_d.rec = rd_a_q;
				rec_d = rd_b_q;
				idx_d = '0;
				state_d = (count_q == '0) ? ST_RESULT : ST_DN_RD;
			end
			ST_DN_RD: begin
				rd_addr_a = l_addr;
				rd_addr_b = r_addr;
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (r_wins) begin
					wr_data = rd_b_q;
					idx_d = rx[IW-1:0];
					state_d = ST_DN_RD;
				end else if (l_best) begin
					wr_data = rd_a_q;
					idx_d = lx[IW-1:0];
					state_d = ST_DN_RD;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (pop_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// heap record memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working record and popped top
	always_ff @(posedge clk) begin
		pop_q <= pop_d;
		rec_q <= rec_d;
		top_q <= top_d;
		idx_q <= idx_d;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign pop_valid = (state_q == ST_RESULT);
	assign pop = top_q;
	assign stat.idle = (state_q == ST_IDLE);
	assign stat.full = (count_q == CW'(STREAMS));
	assign count = count_q;

endmodule

[rtl/core/lmh_filter.sv]
// version filter and result register of the merge heap
// depends on lmh_pkg
module lmh_filter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  lmh_pkg::pop_t pop,
	input  logic [63:0]   snapshot,
	input  logic          bottom,
	output logic          out_valid,
	input  logic          out_ready,
	output lmh_pkg::pop_t out_pop,
	output logic          out_keep
);
	import lmh_pkg::*;

	logic        out_valid_q;
	pop_t        out_pop_q;
	logic        out_keep_q;
	logic        prev_valid_q;
	logic [63:0] prev_key_q;
	logic [3:0]  prev_len_q;
	logic [63:0] last_seq_q;
	logic        take, tomb, new_key, shadowed, keep;

	// keep decision
	always_comb begin
		take = pop_valid && pop_ready;
		tomb = (pop.rec.op == OP_TOMBSTONE) && bottom && (pop.rec.seq <= snapshot);
		new_key = !prev_valid_q || (prev_len_q != pop.rec.len) || (prev_key_q != pop.rec.key);
		shadowed = !new_key && (last_seq_q <= snapshot);
		keep = !pop.empty && !shadowed && !tomb;
	end

	assign pop_ready = !out_valid_q || out_ready;

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_key_q <= '0;
			prev_len_q <= '0;
			last_seq_q <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (take && !pop.empty) begin
				if (new_key) begin
					prev_valid_q <= 1'b1;
					prev_key_q <= pop.rec.key;
					prev_len_q <= pop.rec.len;
					last_seq_q <= pop.rec.seq;
				end else if (!shadowed) begin
					last_seq_q <= pop.rec.seq;
				end
			end
			if (take) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_pop_q <= pop;
			out_keep_q <= keep;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pop = out_pop_q;
	assign out_keep = out_keep_q;

endmodule

[rtl/core/lsm_merge_heap_with_version_filter.sv]
// k-way merge heap with version filter: one record per input stream, sorted
// by key, key length, newest sequence first, then stream. A load request
// inserts a record; a pop request optionally inserts the refill record, then
// removes the minimum and flags it kept or dropped. After the idle state
// takes the request, an insert reads each parent compared and then compares
// and writes, with one more write when it ends at the root; a pop fetches the
// root and the last record, reads and compares each sift-down level including
// the final compare, and hands the result over, waiting while the output
// register is full. The pace is set by the single record memory, read once
// per level through registered read ports. One request is in work at a time;
// a finished result waits in an output register while the next request is
// taken.
// depends on lmh_pkg, lmh_heap, lmh_filter and assert_macros.svh
`include "assert_macros.svh"
module lsm_merge_heap_with_version_filter #(
	parameter int STREAMS = 16,
	parameter int KEY_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// stream_index, user_key, key_length, sequence_req, op_kind, value_tag
	input  logic [175:0] s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// from_stream, out_key, out_key_length, out_sequence, out_op_kind,
	// out_value_tag, keep, zero fill
	output logic [183:0] m_tdata,
	// heap_empty
	output logic [0:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	import lmh_pkg::*;

	localparam int CW = $clog2(STREAMS + 1);

	logic [63:0]   snapshot_q;
	logic          bottom_q;
	rec_t          in_rec;
	logic          pop_valid, pop_ready, out_keep;
	pop_t          pop, out_pop;
	heap_stat_t    stat;
	logic [CW-1:0] count;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snapshot_q <= '0;
			bottom_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				REG_SNAPSHOT: snapshot_q <= pwdata;
				REG_BOTTOM:   bottom_q <= pwdata[0];
				default:      bottom_q <= bottom_q;
			endcase
		end
	end
	assign prdata = (paddr[3] == REG_BOTTOM) ? {63'd0, bottom_q} : snapshot_q;

	// request unpacking
	always_comb begin
		in_rec.stream = s_tdata[3:0];
		in_rec.key = s_tdata[67:4];
		in_rec.len = s_tdata[71:68];
		in_rec.seq = s_tdata[135:72];
		in_rec.op = s_tdata[143:136];
		in_rec.tag = s_tdata[175:144];
	end

	lmh_heap #(.STREAMS(STREAMS), .KEY_BYTES(KEY_BYTES)) u_heap (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_cmd(s_tuser), .in_rec(in_rec),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop(pop),
		.stat(stat), .count(count)
	);

	lmh_filter u_filter (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop(pop),
		.snapshot(snapshot_q), .bottom(bottom_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_pop(out_pop), .out_keep(out_keep)
	);

	// result packing
	assign m_tdata = {7'd0, out_keep, out_pop.rec.tag, out_pop.rec.op, out_pop.rec.seq,
		out_pop.rec.len, out_pop.rec.key, out_pop.rec.stream};
	assign m_tuser = out_pop.empty;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count <= CW'(STREAMS))
	`ASSERT_ALWAYS(a_empty_zero, clk, arst_n, !(m_tvalid && m_tuser[0]) || (m_tdata == '0))
	`ASSERT_NEXT(a_idle_count, clk, arst_n, stat.idle && !s_tvalid, $stable(count))
	`ASSERT_ALWAYS(a_full_count, clk, arst_n, !stat.full || (count == CW'(STREAMS)))

endmodule
